@@ hw/rtl/y2r_pkg.sv @@
// package with widths, coefficients and stage payload types for the yuv to rgb block
package y2r_pkg;

  localparam int unsigned ChanW  = 8;   // every sample and color channel
  localparam int unsigned ChromW = 17;  // chroma products, signed
  localparam int unsigned SumW   = 19;  // 256y plus chroma term, signed
  localparam int unsigned GrayW  = 24;  // weighted gray sum, unsigned, never overflows

  localparam logic signed [ChromW-1:0] CoefRv = 17'sd358;
  localparam logic signed [ChromW-1:0] CoefGu = 17'sd88;
  localparam logic signed [ChromW-1:0] CoefGv = 17'sd182;
  localparam logic signed [ChromW-1:0] CoefBu = 17'sd453;

  // bt.601 luminance weights in q0.16
  localparam logic [GrayW-1:0] GrayR = 24'd19589;
  localparam logic [GrayW-1:0] GrayG = 24'd38444;
  localparam logic [GrayW-1:0] GrayB = 24'd7509;

  typedef logic [ChanW-1:0] chan_t;

  typedef struct packed {
    chan_t luma_first;
    chan_t luma_second;
    chan_t chroma_u;
    chan_t chroma_v;
    chan_t prev_luma_first;
    chan_t prev_luma_second;
    chan_t prev_chroma_u;
    chan_t prev_chroma_v;
  } pix_t;

  typedef struct packed {
    chan_t                    luma_first;
    chan_t                    luma_second;
    logic signed [ChromW-1:0] cr;
    logic signed [ChromW-1:0] cg;
    logic signed [ChromW-1:0] cb;
    logic                     write_first;
    logic                     write_second;
  } chroma_t;

  typedef struct packed {
    chan_t r;
    chan_t g;
    chan_t b;
  } rgb_t;

  typedef struct packed {
    rgb_t first;
    logic write_first;
    rgb_t second;
    logic write_second;
  } rgb_pair_t;

  typedef struct packed {
    logic [GrayW-1:0] r;
    logic [GrayW-1:0] g;
    logic [GrayW-1:0] b;
  } gray_prod_t;

  typedef struct packed {
    rgb_pair_t  color;
    gray_prod_t prod_first;
    gray_prod_t prod_second;
  } gray_mul_t;

endpackage

@@ hw/rtl/y2r_if.sv @@
// valid/ready channel interfaces for pixel pairs, rgb results and the config write

interface y2r_pair_if import y2r_pkg::*; ();
  logic  valid;
  logic  ready;
  chan_t luma_first;
  chan_t luma_second;
  chan_t chroma_u;
  chan_t chroma_v;
  chan_t prev_luma_first;
  chan_t prev_luma_second;
  chan_t prev_chroma_u;
  chan_t prev_chroma_v;

  modport source (
    output valid, luma_first, luma_second, chroma_u, chroma_v,
           prev_luma_first, prev_luma_second, prev_chroma_u, prev_chroma_v,
    input  ready
  );
  modport sink (
    input  valid, luma_first, luma_second, chroma_u, chroma_v,
           prev_luma_first, prev_luma_second, prev_chroma_u, prev_chroma_v,
    output ready
  );
endinterface

interface y2r_rgb_if import y2r_pkg::*; ();
  logic  valid;
  logic  ready;
  chan_t red_first;
  chan_t green_first;
  chan_t blue_first;
  logic  write_first;
  chan_t red_second;
  chan_t green_second;
  chan_t blue_second;
  logic  write_second;

  modport source (
    output valid, red_first, green_first, blue_first, write_first,
           red_second, green_second, blue_second, write_second,
    input  ready
  );
  modport sink (
    input  valid, red_first, green_first, blue_first, write_first,
           red_second, green_second, blue_second, write_second,
    output ready
  );
endinterface

interface y2r_cfg_if;
  logic valid;
  logic ready;
  logic gray_mode;

  modport source (output valid, gray_mode, input ready);
  modport sink (input valid, gray_mode, output ready);
endinterface

@@ hw/rtl/yuv_to_rgb_pixel_pair_skip.sv @@
// top level of the pixel pair yuv to rgb converter with change flags
//
// Converts one pixel pair (two lumas sharing one u/v sample) to clamped
// bt.601 rgb per beat, and flags each pixel for writing unless its luma and
// the shared chroma equal the previous frame's samples. A four-stage pipeline
// (chroma products, rgb sum and clamp, gray weight products, gray sum and
// select) accepts one beat every cycle unless it is full and the output is
// stalled; a pair is registered by each stage in turn. Each stage has its own
// valid bit and a ready that is high whenever the stage is empty or is being
// drained, so bubbles close up and a stalled output only backs up the input
// once all four stages hold data. gray_mode should only be written while the
// pipeline is empty; the config channel is always ready.
module yuv_to_rgb_pixel_pair_skip import y2r_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  y2r_pair_if.sink  pix_i,
  y2r_rgb_if.source rgb_o,
  y2r_cfg_if.sink   cfg_i
);

  // gray mode register, written by config beats
  logic gray_mode_q, gray_mode_d;

  // stage handshakes and payloads
  pix_t      pix_data;
  logic      s1_valid, s1_ready;
  chroma_t   s1_data;
  logic      s2_valid, s2_ready;
  rgb_pair_t s2_data;
  logic      s3_valid, s3_ready;
  gray_mul_t s3_data;
  logic      s4_valid;
  rgb_pair_t s4_data;

  assign cfg_i.ready = 1'b1;
  assign gray_mode_d = cfg_i.valid ? cfg_i.gray_mode : gray_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gray_mode_q <= 1'b0;
    end else begin
      gray_mode_q <= gray_mode_d;
    end
  end

  // gather input fields into the stage payload
  always_comb begin
    pix_data.luma_first       = pix_i.luma_first;
    pix_data.luma_second      = pix_i.luma_second;
    pix_data.chroma_u         = pix_i.chroma_u;
    pix_data.chroma_v         = pix_i.chroma_v;
    pix_data.prev_luma_first  = pix_i.prev_luma_first;
    pix_data.prev_luma_second = pix_i.prev_luma_second;
    pix_data.prev_chroma_u    = pix_i.prev_chroma_u;
    pix_data.prev_chroma_v    = pix_i.prev_chroma_v;
  end

  // stage 1: chroma products and change flags
  y2r_chroma_stage u_chroma (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pix_i.valid),
    .ready_o (pix_i.ready),
    .data_i  (pix_data),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .data_o  (s1_data)
  );

  // stage 2: per-pixel rgb, floor and clamp
  y2r_rgb_stage u_rgb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data)
  );

  // stage 3: luminance weight multiplies
  y2r_gray_mul u_gray_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .data_i  (s2_data),
    .valid_o (s3_valid),
    .ready_i (s3_ready),
    .data_o  (s3_data)
  );

  // stage 4: gray sum, mode select, output register
  y2r_gray_out u_gray_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .gray_mode_i (gray_mode_q),
    .valid_i     (s3_valid),
    .ready_o     (s3_ready),
    .data_i      (s3_data),
    .valid_o     (s4_valid),
    .ready_i     (rgb_o.ready),
    .data_o      (s4_data)
  );

  assign rgb_o.valid        = s4_valid;
  assign rgb_o.red_first    = s4_data.first.r;
  assign rgb_o.green_first  = s4_data.first.g;
  assign rgb_o.blue_first   = s4_data.first.b;
  assign rgb_o.write_first  = s4_data.write_first;
  assign rgb_o.red_second   = s4_data.second.r;
  assign rgb_o.green_second = s4_data.second.g;
  assign rgb_o.blue_second  = s4_data.second.b;
  assign rgb_o.write_second = s4_data.write_second;

  // input only backs up when every stage is full and the output is stalled
  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_i.ready |-> (s1_valid && s2_valid && s3_valid && s4_valid && !rgb_o.ready))
    else $error("input stalled with a bubble in the pipeline");

  // a stage whose successor is stalled keeps its beat
  a_s2_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid && !s2_ready) |=> s2_valid)
    else $error("stage 2 beat dropped under stall");

  // gray mode puts one value on all three channels of each pixel
  a_gray_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rgb_o.valid && gray_mode_q) |->
      (rgb_o.red_first == rgb_o.green_first && rgb_o.green_first == rgb_o.blue_first &&
       rgb_o.red_second == rgb_o.green_second && rgb_o.green_second == rgb_o.blue_second))
    else $error("gray output channels differ");

endmodule

@@ hw/rtl/y2r_chroma_stage.sv @@
// stage 1: chroma offset removal, chroma products and change flags
module y2r_chroma_stage import y2r_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    ready_o,
  input  pix_t    data_i,
  output logic    valid_o,
  input  logic    ready_i,
  output chroma_t data_o
);

  logic                     valid_q, valid_d, load;
  chroma_t                  data_q, data_d;
  logic signed [ChanW-1:0]  u_s, v_s;
  logic signed [ChromW-1:0] u_x, v_x;
  logic                     chroma_same;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;
  assign valid_d = ready_o ? valid_i : valid_q;

  // x - 128 on an 8-bit sample is an msb flip
  assign u_s = signed'({~data_i.chroma_u[ChanW-1], data_i.chroma_u[ChanW-2:0]});
  assign v_s = signed'({~data_i.chroma_v[ChanW-1], data_i.chroma_v[ChanW-2:0]});
  assign u_x = ChromW'(u_s);
  assign v_x = ChromW'(v_s);

  assign chroma_same = (data_i.chroma_u == data_i.prev_chroma_u) &&
                       (data_i.chroma_v == data_i.prev_chroma_v);

  always_comb begin
    data_d.luma_first   = data_i.luma_first;
    data_d.luma_second  = data_i.luma_second;
    data_d.cr           = v_x * CoefRv;
    data_d.cg           = -(u_x * CoefGu) - (v_x * CoefGv);
    data_d.cb           = u_x * CoefBu;
    data_d.write_first  = !(chroma_same && (data_i.luma_first == data_i.prev_luma_first));
    data_d.write_second = !(chroma_same && (data_i.luma_second == data_i.prev_luma_second));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ hw/rtl/y2r_rgb_stage.sv @@
// stage 2: luma plus chroma terms, floor shift and clamp for both pixels
module y2r_rgb_stage import y2r_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  chroma_t   data_i,
  output logic      valid_o,
  input  logic      ready_i,
  output rgb_pair_t data_o
);

  // floor(s / 256) clamped to 0..255, read straight off the bits
  function automatic chan_t clamp_shift8(input logic signed [SumW-1:0] s);
    chan_t res;
    if (s[SumW-1]) begin
      res = '0;
    end else if (|s[SumW-2:16]) begin
      res = '1;
    end else begin
      res = s[15:8];
    end
    return res;
  endfunction

  function automatic rgb_t pixel_rgb(input chan_t y, input chroma_t c);
    logic signed [SumW-1:0] base;
    rgb_t                   res;
    base  = SumW'(signed'({1'b0, y, 8'h00}));
    res.r = clamp_shift8(base + SumW'(c.cr));
    res.g = clamp_shift8(base + SumW'(c.cg));
    res.b = clamp_shift8(base + SumW'(c.cb));
    return res;
  endfunction

  logic      valid_q, valid_d, load;
  rgb_pair_t data_q, data_d;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_comb begin
    data_d.first        = pixel_rgb(data_i.luma_first, data_i);
    data_d.write_first  = data_i.write_first;
    data_d.second       = pixel_rgb(data_i.luma_second, data_i);
    data_d.write_second = data_i.write_second;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ hw/rtl/y2r_gray_mul.sv @@
// stage 3: luminance weight products for both pixels, color passed along
module y2r_gray_mul import y2r_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  rgb_pair_t data_i,
  output logic      valid_o,
  input  logic      ready_i,
  output gray_mul_t data_o
);

  function automatic gray_prod_t weigh(input rgb_t c);
    gray_prod_t res;
    res.r = GrayW'(c.r) * GrayR;
    res.g = GrayW'(c.g) * GrayG;
    res.b = GrayW'(c.b) * GrayB;
    return res;
  endfunction

  logic      valid_q, valid_d, load;
  gray_mul_t data_q, data_d;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_comb begin
    data_d.color       = data_i;
    data_d.prod_first  = weigh(data_i.first);
    data_d.prod_second = weigh(data_i.second);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ hw/rtl/y2r_gray_out.sv @@
// stage 4: gray sum and color/gray select into the output register
module y2r_gray_out import y2r_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      gray_mode_i,
  input  logic      valid_i,
  output logic      ready_o,
  input  gray_mul_t data_i,
  output logic      valid_o,
  input  logic      ready_i,
  output rgb_pair_t data_o
);

  // weights sum to just over 1.0, but 255 * sum stays below 256 << 16,
  // so the top byte is already the clamped value
  function automatic rgb_t gray_of(input gray_prod_t p);
    logic [GrayW-1:0] s;
    rgb_t             res;
    s     = p.r + p.g + p.b;
    res.r = s[GrayW-1:GrayW-ChanW];
    res.g = s[GrayW-1:GrayW-ChanW];
    res.b = s[GrayW-1:GrayW-ChanW];
    return res;
  endfunction

  logic      valid_q, valid_d, load;
  rgb_pair_t data_q, data_d;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_comb begin
    data_d = data_i.color;
    if (gray_mode_i) begin
      data_d.first  = gray_of(data_i.prod_first);
      data_d.second = gray_of(data_i.prod_second);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ verif/y2r_pair_checker.sv @@
`timescale 1ns / 1ps
// checker that predicts the rgb pair for every accepted pixel beat and compares the results
module y2r_pair_checker import y2r_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  y2r_pair_if  pix_i,
  y2r_rgb_if   rgb_i,
  y2r_cfg_if   cfg_i,
  output int   mismatch_cnt_o,
  output int   pending_cnt_o,
  output int   checked_cnt_o,
  output int   unchanged_cnt_o
);

  rgb_pair_t expected_pairs[$];
  rgb_pair_t want_pair;
  pix_t      beat;
  logic      gray_shadow   = 1'b0;
  int        mismatch_cnt  = 0;
  int        checked_cnt   = 0;
  int        unchanged_cnt = 0;

  assign mismatch_cnt_o  = mismatch_cnt;
  assign pending_cnt_o   = expected_pairs.size();
  assign checked_cnt_o   = checked_cnt;
  assign unchanged_cnt_o = unchanged_cnt;

  function automatic chan_t clip8(int x);
    if (x < 0) return '0;
    if (x > 255) return 8'd255;
    return chan_t'(x);
  endfunction

  // bt.601 in 8-bit fixed point, floor shift, then optional gray weighting
  function automatic rgb_t pixel_color(chan_t y, int u, int v, logic gray);
    int   scaled_y;
    int   gray_sum;
    rgb_t px;
    scaled_y = y;
    scaled_y = scaled_y * 256;
    px.r = clip8((scaled_y + 358 * v) >>> 8);
    px.g = clip8((scaled_y - 88 * u - 182 * v) >>> 8);
    px.b = clip8((scaled_y + 453 * u) >>> 8);
    if (gray) begin
      gray_sum = (19589 * px.r + 38444 * px.g + 7509 * px.b) >> 16;
      px.r = clip8(gray_sum);
      px.g = px.r;
      px.b = px.r;
    end
    return px;
  endfunction

  function automatic rgb_pair_t predict_pair(pix_t p, logic gray);
    int        u;
    int        v;
    logic      chroma_same;
    rgb_pair_t res;
    u = p.chroma_u;
    u = u - 128;
    v = p.chroma_v;
    v = v - 128;
    chroma_same = (p.chroma_u == p.prev_chroma_u) && (p.chroma_v == p.prev_chroma_v);
    res.first        = pixel_color(p.luma_first, u, v, gray);
    res.second       = pixel_color(p.luma_second, u, v, gray);
    res.write_first  = !(chroma_same && p.luma_first == p.prev_luma_first);
    res.write_second = !(chroma_same && p.luma_second == p.prev_luma_second);
    return res;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    mismatch_cnt++;
    $display("[%0t] mismatch on %s: got %0d, want %0d", $time, field, got, want);
  endtask

  task automatic check_pair(rgb_pair_t want);
    if (rgb_i.red_first !== want.first.r)
      report_mismatch("red_first", rgb_i.red_first, want.first.r);
    if (rgb_i.green_first !== want.first.g)
      report_mismatch("green_first", rgb_i.green_first, want.first.g);
    if (rgb_i.blue_first !== want.first.b)
      report_mismatch("blue_first", rgb_i.blue_first, want.first.b);
    if (rgb_i.write_first !== want.write_first)
      report_mismatch("write_first", rgb_i.write_first, want.write_first);
    if (rgb_i.red_second !== want.second.r)
      report_mismatch("red_second", rgb_i.red_second, want.second.r);
    if (rgb_i.green_second !== want.second.g)
      report_mismatch("green_second", rgb_i.green_second, want.second.g);
    if (rgb_i.blue_second !== want.second.b)
      report_mismatch("blue_second", rgb_i.blue_second, want.second.b);
    if (rgb_i.write_second !== want.write_second)
      report_mismatch("write_second", rgb_i.write_second, want.write_second);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_pairs.delete();
      gray_shadow = 1'b0;
    end else begin
      // results first, a beat accepted now cannot come out in the same cycle
      if (rgb_i.valid && rgb_i.ready) begin
        if (expected_pairs.size() == 0) begin
          report_mismatch("result beat with nothing expected", 1, 0);
        end else begin
          want_pair = expected_pairs.pop_front();
          check_pair(want_pair);
          checked_cnt++;
        end
      end
      if (pix_i.valid && pix_i.ready) begin
        beat = '{pix_i.luma_first, pix_i.luma_second, pix_i.chroma_u, pix_i.chroma_v,
                 pix_i.prev_luma_first, pix_i.prev_luma_second,
                 pix_i.prev_chroma_u, pix_i.prev_chroma_v};
        want_pair = predict_pair(beat, gray_shadow);
        if (!want_pair.write_first || !want_pair.write_second) unchanged_cnt++;
        expected_pairs.push_back(want_pair);
      end
      if (cfg_i.valid && cfg_i.ready) gray_shadow = cfg_i.gray_mode;
    end
  end

endmodule

@@ verif/yuv_to_rgb_pixel_pair_skip_tb.sv @@
`timescale 1ns / 1ps
// top of the testbench: clock, reset, pixel and config stimulus, output stalls and verdict
module yuv_to_rgb_pixel_pair_skip_tb;
  import y2r_pkg::*;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  y2r_pair_if pix_if ();
  y2r_rgb_if  rgb_if ();
  y2r_cfg_if  cfg_if ();

  // idle percentages of the current phase, set by the main sequence
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // long output hold-off: requested by the main sequence, counted by the ready process
  bit hold_go   = 1'b0;
  bit hold_done = 1'b0;
  int hold_cnt  = 0;

  int beats_sent = 0;
  int cfg_writes = 0;

  int mismatch_cnt;
  int pending_cnt;
  int checked_cnt;
  int unchanged_cnt;

  yuv_to_rgb_pixel_pair_skip dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .pix_i  (pix_if),
    .rgb_o  (rgb_if),
    .cfg_i  (cfg_if)
  );

  y2r_pair_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .pix_i           (pix_if),
    .rgb_i           (rgb_if),
    .cfg_i           (cfg_if),
    .mismatch_cnt_o  (mismatch_cnt),
    .pending_cnt_o   (pending_cnt),
    .checked_cnt_o   (checked_cnt),
    .unchanged_cnt_o (unchanged_cnt)
  );

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // output side: random stalls per phase, or a long counted hold-off when asked
  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      rgb_if.ready <= 1'b0;
      hold_cnt++;
      if (hold_cnt >= 300) hold_done = 1'b1;
    end else begin
      rgb_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // hard stop far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // drive one pixel pair beat, after a random gap, and wait for its handshake
  task automatic send_pair(input pix_t p);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
    // valid only drops when a gap follows, so back to back beats keep it high
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_if.valid            <= 1'b1;
    pix_if.luma_first       <= p.luma_first;
    pix_if.luma_second      <= p.luma_second;
    pix_if.chroma_u         <= p.chroma_u;
    pix_if.chroma_v         <= p.chroma_v;
    pix_if.prev_luma_first  <= p.prev_luma_first;
    pix_if.prev_luma_second <= p.prev_luma_second;
    pix_if.prev_chroma_u    <= p.prev_chroma_u;
    pix_if.prev_chroma_v    <= p.prev_chroma_v;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    beats_sent++;
  endtask

  // stop offering beats and wait until every expected pair has come out
  task automatic wait_pipeline_empty();
    pix_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    // extra margin after the last expected pair has come out
    repeat (8) @(posedge clk);
  endtask

  // gray_mode is only written with the pipeline empty
  task automatic write_gray_mode(input logic mode);
    wait_pipeline_empty();
    cfg_if.valid     <= 1'b1;
    cfg_if.gray_mode <= mode;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    cfg_writes++;
  endtask

  // hand-picked pairs: range extremes, unchanged pixels and every chroma change case
  function automatic pix_t directed_pair(int idx);
    pix_t p;
    case (idx)
      // everything zero: both pixels unchanged, chroma at its negative extreme
      0: p = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
      // everything full scale
      1: p = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
      // clamp high or low on the channels each pair can reach
      2: p = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0};
      3: p = '{8'd0, 8'd0, 8'd0, 8'd255, 8'd1, 8'd1, 8'd1, 8'd1};
      4: p = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 8'd254, 8'd0};
      // neutral chroma, unchanged pixels carrying their computed value
      5: p = '{8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128};
      // chroma kept, only the second luma moved
      6: p = '{8'd10, 8'd200, 8'd90, 8'd160, 8'd10, 8'd201, 8'd90, 8'd160};
      // chroma kept, only the first luma moved
      7: p = '{8'd77, 8'd33, 8'd200, 8'd40, 8'd78, 8'd33, 8'd200, 8'd40};
      // only u changed: both pixels flagged even with equal luma
      8: p = '{8'd60, 8'd61, 8'd100, 8'd150, 8'd60, 8'd61, 8'd101, 8'd150};
      // only v changed
      9: p = '{8'd190, 8'd5, 8'd30, 8'd220, 8'd190, 8'd5, 8'd30, 8'd219};
      10: p = '{8'd255, 8'd0, 8'd0, 8'd0, 8'd254, 8'd1, 8'd0, 8'd0};
      default: p = '{8'd16, 8'd235, 8'd16, 8'd240, 8'd16, 8'd235, 8'd16, 8'd240};
    endcase
    return p;
  endfunction

  function automatic chan_t extreme_sample();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd127;
      3: return 8'd128;
      4: return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  // random pairs, biased so that kept chroma and kept luma show up often
  function automatic pix_t random_pair();
    pix_t p;
    int   kind;
    p    = pix_t'({$urandom(), $urandom()});
    kind = $urandom_range(0, 9);
    if (kind >= 4 && kind <= 7) begin
      // chroma kept, each luma kept half the time
      p.prev_chroma_u = p.chroma_u;
      p.prev_chroma_v = p.chroma_v;
      if ($urandom_range(0, 1)) p.prev_luma_first = p.luma_first;
      if ($urandom_range(0, 1)) p.prev_luma_second = p.luma_second;
    end else if (kind == 8) begin
      p.luma_first  = extreme_sample();
      p.luma_second = extreme_sample();
      p.chroma_u    = extreme_sample();
      p.chroma_v    = extreme_sample();
      if ($urandom_range(0, 1)) begin
        p.prev_chroma_u   = p.chroma_u;
        p.prev_chroma_v   = p.chroma_v;
        p.prev_luma_first = p.luma_first;
      end
    end else if (kind == 9) begin
      // one chroma sample changed in a single bit, lumas kept
      p.prev_luma_first  = p.luma_first;
      p.prev_luma_second = p.luma_second;
      p.prev_chroma_u    = p.chroma_u;
      p.prev_chroma_v    = p.chroma_v;
      if ($urandom_range(0, 1)) p.prev_chroma_u = p.chroma_u ^ (8'd1 << $urandom_range(0, 7));
      else                      p.prev_chroma_v = p.chroma_v ^ (8'd1 << $urandom_range(0, 7));
    end
    return p;
  endfunction

  initial begin
    pix_if.valid            = 1'b0;
    pix_if.luma_first       = '0;
    pix_if.luma_second      = '0;
    pix_if.chroma_u         = '0;
    pix_if.chroma_v         = '0;
    pix_if.prev_luma_first  = '0;
    pix_if.prev_luma_second = '0;
    pix_if.prev_chroma_u    = '0;
    pix_if.prev_chroma_v    = '0;
    rgb_if.ready            = 1'b0;
    cfg_if.valid            = 1'b0;
    cfg_if.gray_mode        = 1'b0;

    // reset held low from the start, released on a clock edge
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pairs in color and then in gray mode
    write_gray_mode(1'b0);
    for (int i = 0; i < 12; i++) send_pair(directed_pair(i));
    write_gray_mode(1'b1);
    for (int i = 0; i < 12; i++) send_pair(directed_pair(i));

    // random phases: no idling, sender idle, receiver stalling, both a little
    for (int phase = 0; phase < 4; phase++) begin
      for (int gray = 0; gray < 2; gray++) begin
        write_gray_mode(gray[0]);
        case (phase)
          0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
          1: begin send_idle_pct = 72; recv_idle_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_idle_pct = 72; end
          default: begin send_idle_pct = 12; recv_idle_pct = 12; end
        endcase
        for (int i = 0; i < 170; i++) send_pair(random_pair());
      end
    end

    // long output hold-off while beats keep coming, so the pipeline fills and backs up
    write_gray_mode(1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_go = 1'b1;
    for (int i = 0; i < 40; i++) send_pair(random_pair());
    while (!hold_done) @(posedge clk);

    wait_pipeline_empty();

    $display("run covered %0d pixel pair beats and %0d checked results, %0d with a kept pixel",
             beats_sent, checked_cnt, unchanged_cnt);
    $display("both gray_mode settings over %0d config writes, four idle phases, one long stall",
             cfg_writes);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
